// ===== rtl/core/sdrp_pkg.sv =====
// Shared types and constants for the straight-drive ramp profile unit.
package sdrp_pkg;

	// Field widths fixed by the register map and the beat formats
	localparam int DIST_W    = 23;
	localparam int PWR_W     = 7;
	localparam int GAIN_W    = 16;
	localparam int TIME_W    = 16;
	localparam int DIR_W     = 2;
	localparam int OUT_W     = 8;
	localparam int OUT_LIMIT = 127;
	localparam int FRAC_W    = 8;

	// Ramp fraction never exceeds the power span, so seven quotient bits suffice
	localparam int Q_W    = PWR_W;
	localparam int NUM_W  = DIST_W + PWR_W;
	localparam int SPAN_W = PWR_W + 1;
	localparam int RAMP_W = PWR_W + 3;

	// Configuration port
	localparam int IDX_W = 3;
	localparam int REG_W = DIST_W;

	typedef enum logic [IDX_W-1:0] {
		REG_DIRECTION,
		REG_TOTAL,
		REG_ACCEL,
		REG_DECEL,
		REG_MAX_POWER,
		REG_MIN_POWER,
		REG_DRIFT_GAIN,
		REG_TIMEOUT
	} reg_index_t;

	// Direction codes; any other code counts as reverse
	localparam logic [DIR_W-1:0] DIR_STOP = 2'b00;
	localparam logic [DIR_W-1:0] DIR_FWD  = 2'b01;

	// How the ramp power is formed for one beat
	typedef enum logic [1:0] {
		RAMP_DIV,
		RAMP_FLAT,
		RAMP_ZERO
	} ramp_mode_t;

	typedef struct packed {
		logic       done;
		logic       tout;
		ramp_mode_t mode;
	} item_ctrl_t;

	typedef struct packed {
		logic signed [DIR_W-1:0]  direction;
		logic [DIST_W-1:0]        total_distance;
		logic [DIST_W-1:0]        accel_distance;
		logic [DIST_W-1:0]        decel_start;
		logic [PWR_W-1:0]         max_power;
		logic [PWR_W-1:0]         min_power;
		logic signed [GAIN_W-1:0] drift_gain;
		logic [TIME_W-1:0]        timeout_ms;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		direction:      2'sb01,
		total_distance: '0,
		accel_distance: 23'd1,
		decel_start:    '0,
		max_power:      7'd127,
		min_power:      '0,
		drift_gain:     '0,
		timeout_ms:     16'hFFFF
	};

endpackage

// ===== rtl/core/sdrp_sample_if.sv =====
// Sample channel: encoder counts and elapsed time.
interface sdrp_sample_if import sdrp_pkg::*; #(
	parameter int COUNT_WIDTH = 24
);
	logic                          valid;
	logic                          ready;
	logic signed [COUNT_WIDTH-1:0] left_count;
	logic signed [COUNT_WIDTH-1:0] right_count;
	logic [TIME_W-1:0]             elapsed_ms;

	modport source (output valid, left_count, right_count, elapsed_ms, input ready);
	modport sink (input valid, left_count, right_count, elapsed_ms, output ready);
endinterface

// ===== rtl/core/sdrp_command_if.sv =====
// Command channel: motor power commands and run status.
interface sdrp_command_if import sdrp_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] left_power;
	logic signed [OUT_W-1:0] right_power;
	logic                    finished;
	logic                    timed_out;

	modport source (output valid, left_power, right_power, finished, timed_out, input ready);
	modport sink (input valid, left_power, right_power, finished, timed_out, output ready);
endinterface

// ===== rtl/core/straight_drive_ramp_profile_unit.sv =====
// Straight-drive ramp profile unit: top level with the register file.
// Path: sample beat to command beat through 3 front, 7 divider and 3 back stages.
// Throughput: one beat per cycle while command.ready holds; each of the 13 stages advances
// when empty or when the next one moves, so bubbles close up under output stall.
// The ramp fraction divider yields one quotient bit per stage.
// Reset: pipeline emptied, registers return to their defaults.
module straight_drive_ramp_profile_unit import sdrp_pkg::*; #(
	parameter int COUNT_WIDTH = 24,
	parameter int POWER_LIMIT = 127
) (
	input  logic              clk,
	input  logic              arst_n,
	sdrp_sample_if.sink       sample,
	sdrp_command_if.source    command,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_index,
	input  logic [REG_W-1:0]  wr_data
);

	localparam int PROD_W = GAIN_W + COUNT_WIDTH + 1;

	cfg_t cfg_q;

	logic                     f_valid, f_ready;
	logic [NUM_W-1:0]         f_num;
	logic [DIST_W-1:0]        f_den;
	item_ctrl_t               f_ctrl;
	logic signed [PROD_W-1:0] f_prod;

	logic                     d_valid, d_ready;
	logic [Q_W-1:0]           d_quot;
	item_ctrl_t               d_ctrl;
	logic [PROD_W-1:0]        d_side;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (wr_en) begin
			case (reg_index_t'(wr_index))
				REG_DIRECTION:  cfg_q.direction      <= wr_data[DIR_W-1:0];
				REG_TOTAL:      cfg_q.total_distance <= wr_data[DIST_W-1:0];
				REG_ACCEL:      cfg_q.accel_distance <= wr_data[DIST_W-1:0];
				REG_DECEL:      cfg_q.decel_start    <= wr_data[DIST_W-1:0];
				REG_MAX_POWER:  cfg_q.max_power      <= wr_data[PWR_W-1:0];
				REG_MIN_POWER:  cfg_q.min_power      <= wr_data[PWR_W-1:0];
				REG_DRIFT_GAIN: cfg_q.drift_gain     <= wr_data[GAIN_W-1:0];
				REG_TIMEOUT:    cfg_q.timeout_ms     <= wr_data[TIME_W-1:0];
				default:        cfg_q                <= cfg_q;
			endcase
		end
	end

	sdrp_front #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (sample.valid),
		.in_ready   (sample.ready),
		.left_count (sample.left_count),
		.right_count(sample.right_count),
		.elapsed_ms (sample.elapsed_ms),
		.out_valid  (f_valid),
		.out_ready  (f_ready),
		.num        (f_num),
		.den        (f_den),
		.ctrl       (f_ctrl),
		.prod       (f_prod)
	);

	sdrp_div #(
		.SIDE_W(PROD_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (f_valid),
		.in_ready (f_ready),
		.num      (f_num),
		.den      (f_den),
		.ctrl     (f_ctrl),
		.side     (f_prod),
		.out_valid(d_valid),
		.out_ready(d_ready),
		.quot     (d_quot),
		.ctrl_out (d_ctrl),
		.side_out (d_side)
	);

	sdrp_mix #(
		.COUNT_WIDTH(COUNT_WIDTH),
		.POWER_LIMIT(POWER_LIMIT)
	) u_mix (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (d_valid),
		.in_ready   (d_ready),
		.quot       (d_quot),
		.ctrl       (d_ctrl),
		.prod       ($signed(d_side)),
		.out_valid  (command.valid),
		.out_ready  (command.ready),
		.left_power (command.left_power),
		.right_power(command.right_power),
		.finished   (command.finished),
		.timed_out  (command.timed_out)
	);

endmodule

// ===== rtl/core/sdrp_front.sv =====
// Front stages: average and drift, ramp region select, ramp and drift products.
module sdrp_front import sdrp_pkg::*; #(
	parameter int COUNT_WIDTH = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cfg_t                          cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COUNT_WIDTH-1:0] left_count,
	input  logic signed [COUNT_WIDTH-1:0] right_count,
	input  logic [TIME_W-1:0]             elapsed_ms,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [NUM_W-1:0]              num,
	output logic [DIST_W-1:0]             den,
	output item_ctrl_t                    ctrl,
	output logic signed [GAIN_W+COUNT_WIDTH:0] prod
);

	localparam int CW     = COUNT_WIDTH;
	localparam int AW     = (CW > DIST_W) ? CW : DIST_W;
	localparam int PROD_W = GAIN_W + CW + 1;

	logic v_s1, v_s2, v_s3;
	logic ld1, ld2, ld3;

	// Stage 1 signals
	logic signed [CW:0] sum_c;
	logic [CW:0]        mag_c;
	logic signed [CW:0] drift_c;
	logic               tout_c;
	logic [CW-1:0]      avg_s1;
	logic signed [CW:0] drift_s1;
	logic               tout_s1;

	// Stage 2 signals
	logic [AW-1:0]     avg_x, total_x, accel_x, decel_x, left_x;
	logic [DIST_W:0]   fden_c;
	logic              done_c;
	logic [DIST_W-1:0] n_c, den_c;
	ramp_mode_t        mode_c;
	logic [DIST_W-1:0] n_s2, den_s2;
	ramp_mode_t        mode_s2;
	logic              done_s2, tout_s2;
	logic signed [CW:0] drift_s2;

	// Stage 3 signals
	logic signed [SPAN_W-1:0] span_c;
	logic [SPAN_W-1:0]        span_abs_c;
	logic [NUM_W-1:0]         num_c;
	logic signed [PROD_W-1:0] prod_c;
	logic [NUM_W-1:0]         num_s3;
	logic [DIST_W-1:0]        den_s3;
	item_ctrl_t               ctrl_s3;
	logic signed [PROD_W-1:0] prod_s3;

	// Advance a stage when it is empty or the one after it advances
	assign ld3      = !v_s3 || out_ready;
	assign ld2      = !v_s2 || ld3;
	assign ld1      = !v_s1 || ld2;
	assign in_ready = ld1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (ld1) v_s1 <= in_valid;
			if (ld2) v_s2 <= v_s1;
			if (ld3) v_s3 <= v_s2;
		end
	end

	// Average magnitude (truncated toward zero), drift and timeout
	assign sum_c   = (CW+1)'(left_count) + (CW+1)'(right_count);
	assign mag_c   = sum_c[CW] ? (CW+1)'(-sum_c) : (CW+1)'(sum_c);
	assign drift_c = (CW+1)'(left_count) - (CW+1)'(right_count);
	assign tout_c  = elapsed_ms > cfg.timeout_ms;

	always_ff @(posedge clk) begin
		if (ld1) begin
			avg_s1   <= mag_c[CW:1];
			drift_s1 <= drift_c;
			tout_s1  <= tout_c;
		end
	end

	// Pick the ramp region and the divide operands
	assign avg_x   = AW'(avg_s1);
	assign total_x = AW'(cfg.total_distance);
	assign accel_x = AW'(cfg.accel_distance);
	assign decel_x = AW'(cfg.decel_start);
	assign left_x  = total_x - avg_x;
	assign fden_c  = {1'b0, cfg.total_distance} - {1'b0, cfg.decel_start};
	assign done_c  = tout_s1 || (avg_x >= total_x);

	always_comb begin
		if (avg_x <= accel_x) begin
			n_c    = avg_x[DIST_W-1:0];
			den_c  = cfg.accel_distance;
			mode_c = (cfg.accel_distance == '0) ? RAMP_ZERO : RAMP_DIV;
		end else if (avg_x >= decel_x) begin
			n_c    = left_x[DIST_W-1:0];
			den_c  = fden_c[DIST_W-1:0];
			mode_c = (!fden_c[DIST_W] && (fden_c != '0)) ? RAMP_DIV : RAMP_ZERO;
		end else begin
			n_c    = '0;
			den_c  = cfg.accel_distance;
			mode_c = RAMP_FLAT;
		end
	end

	always_ff @(posedge clk) begin
		if (ld2) begin
			n_s2     <= n_c;
			den_s2   <= den_c;
			mode_s2  <= mode_c;
			done_s2  <= done_c;
			tout_s2  <= tout_s1;
			drift_s2 <= drift_s1;
		end
	end

	// Scale the distance by the span magnitude and the drift by the gain
	assign span_c     = $signed({1'b0, cfg.max_power}) - $signed({1'b0, cfg.min_power});
	assign span_abs_c = span_c[SPAN_W-1] ? SPAN_W'(-span_c) : SPAN_W'(span_c);
	assign num_c      = NUM_W'(n_s2) * NUM_W'(span_abs_c[PWR_W-1:0]);
	assign prod_c     = PROD_W'(cfg.drift_gain) * PROD_W'(drift_s2);

	always_ff @(posedge clk) begin
		if (ld3) begin
			num_s3       <= num_c;
			den_s3       <= den_s2;
			ctrl_s3.done <= done_s2;
			ctrl_s3.tout <= tout_s2;
			ctrl_s3.mode <= mode_s2;
			prod_s3      <= prod_c;
		end
	end

	assign out_valid = v_s3;
	assign num       = num_s3;
	assign den       = den_s3;
	assign ctrl      = ctrl_s3;
	assign prod      = prod_s3;

endmodule

// ===== rtl/core/sdrp_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, side data carried along.
module sdrp_div import sdrp_pkg::*; #(
	parameter int SIDE_W = 41
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [NUM_W-1:0]  num,
	input  logic [DIST_W-1:0] den,
	input  item_ctrl_t        ctrl,
	input  logic [SIDE_W-1:0] side,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [Q_W-1:0]    quot,
	output item_ctrl_t        ctrl_out,
	output logic [SIDE_W-1:0] side_out
);

	// Stage registers
	logic [Q_W:1]      v_s;
	logic [DIST_W-1:0] rem_s  [1:Q_W];
	logic [Q_W-1:0]    low_s  [1:Q_W];
	logic [Q_W-1:0]    q_s    [1:Q_W];
	logic [DIST_W-1:0] den_s  [1:Q_W];
	item_ctrl_t        ctrl_s [1:Q_W];
	logic [SIDE_W-1:0] side_s [1:Q_W];

	// Values entering each stage and the step results
	logic [Q_W+1:1]    ld;
	logic [Q_W:1]      p_v;
	logic [DIST_W-1:0] p_rem  [1:Q_W];
	logic [Q_W-1:0]    p_low  [1:Q_W];
	logic [Q_W-1:0]    p_q    [1:Q_W];
	logic [DIST_W-1:0] p_den  [1:Q_W];
	item_ctrl_t        p_ctrl [1:Q_W];
	logic [SIDE_W-1:0] p_side [1:Q_W];
	logic [DIST_W:0]   trial  [1:Q_W];
	logic [DIST_W:0]   diff   [1:Q_W];
	logic [Q_W:1]      ge;
	logic [DIST_W-1:0] n_rem  [1:Q_W];

	// Ready chain and stage inputs; the quotient is below 2^Q_W, so the
	// upper numerator bits already form a remainder smaller than the divisor
	always_comb begin
		ld[Q_W+1] = out_ready;
		for (int k = Q_W; k >= 1; k--) begin
			ld[k] = !v_s[k] || ld[k+1];
		end

		p_v[1]    = in_valid;
		p_rem[1]  = num[NUM_W-1:Q_W];
		p_low[1]  = num[Q_W-1:0];
		p_q[1]    = '0;
		p_den[1]  = den;
		p_ctrl[1] = ctrl;
		p_side[1] = side;
		for (int k = 2; k <= Q_W; k++) begin
			p_v[k]    = v_s[k-1];
			p_rem[k]  = rem_s[k-1];
			p_low[k]  = low_s[k-1];
			p_q[k]    = q_s[k-1];
			p_den[k]  = den_s[k-1];
			p_ctrl[k] = ctrl_s[k-1];
			p_side[k] = side_s[k-1];
		end

		// Shift in the next numerator bit and subtract where it fits
		for (int k = 1; k <= Q_W; k++) begin
			trial[k] = {p_rem[k], p_low[k][Q_W-1]};
			diff[k]  = trial[k] - {1'b0, p_den[k]};
			ge[k]    = trial[k] >= {1'b0, p_den[k]};
			n_rem[k] = ge[k] ? diff[k][DIST_W-1:0] : trial[k][DIST_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			for (int k = 1; k <= Q_W; k++) begin
				if (ld[k]) v_s[k] <= p_v[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 1; k <= Q_W; k++) begin
			if (ld[k]) begin
				rem_s[k]  <= n_rem[k];
				low_s[k]  <= {p_low[k][Q_W-2:0], 1'b0};
				q_s[k]    <= {p_q[k][Q_W-2:0], ge[k]};
				den_s[k]  <= p_den[k];
				ctrl_s[k] <= p_ctrl[k];
				side_s[k] <= p_side[k];
			end
		end
	end

	assign in_ready  = ld[1];
	assign out_valid = v_s[Q_W];
	assign quot      = q_s[Q_W];
	assign ctrl_out  = ctrl_s[Q_W];
	assign side_out  = side_s[Q_W];

endmodule

// ===== rtl/core/sdrp_mix.sv =====
// Back stages: ramp power and direction, drift correction, saturation to commands.
module sdrp_mix import sdrp_pkg::*; #(
	parameter int COUNT_WIDTH = 24,
	parameter int POWER_LIMIT = 127
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  cfg_t                               cfg,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [Q_W-1:0]                     quot,
	input  item_ctrl_t                         ctrl,
	input  logic signed [GAIN_W+COUNT_WIDTH:0] prod,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [OUT_W-1:0]            left_power,
	output logic signed [OUT_W-1:0]            right_power,
	output logic                               finished,
	output logic                               timed_out
);

	localparam int PROD_W = GAIN_W + COUNT_WIDTH + 1;
	localparam int SUM_W  = PROD_W + 1;
	localparam int T_W    = SUM_W - FRAC_W;
	localparam int LIM_W  = 17;
	localparam logic signed [LIM_W-1:0] LIM = LIM_W'(POWER_LIMIT);

	logic v_s1, v_s2, v_s3;
	logic ld1, ld2, ld3;

	logic signed [SPAN_W-1:0] span_c;
	logic signed [RAMP_W-1:0] qv_c, ramp_c, lvl_c, cl_c, base_c;
	logic signed [LIM_W-1:0]  lvl_x, clx_c;
	logic signed [RAMP_W-1:0] base_s1;
	logic signed [PROD_W-1:0] prod_s1;
	logic                     done_s1, tout_s1;

	logic signed [SUM_W-1:0]  scaled_c;
	logic signed [SUM_W-1:0]  pl_s2, pr_s2;
	logic                     done_s2, tout_s2;

	logic signed [OUT_W-1:0]  left_s3, right_s3;
	logic                     done_s3, tout_s3;

	// Divide by 2^FRAC_W toward zero, then saturate to the command range
	function automatic logic signed [OUT_W-1:0] to_cmd(input logic signed [SUM_W-1:0] v);
		logic signed [T_W-1:0] t;
		logic                  rnd;
		t   = $signed(v[SUM_W-1:FRAC_W]);
		rnd = v[SUM_W-1] && (v[FRAC_W-1:0] != '0);
		if (rnd) t = t + T_W'(1);
		if (t > OUT_LIMIT) return OUT_W'(OUT_LIMIT);
		if (t < -OUT_LIMIT) return OUT_W'(-OUT_LIMIT);
		return t[OUT_W-1:0];
	endfunction

	// Advance a stage when it is empty or the one after it advances
	assign ld3      = !v_s3 || out_ready;
	assign ld2      = !v_s2 || ld3;
	assign ld1      = !v_s1 || ld2;
	assign in_ready = ld1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (ld1) v_s1 <= in_valid;
			if (ld2) v_s2 <= v_s1;
			if (ld3) v_s3 <= v_s2;
		end
	end

	// Ramp power: signed quotient, full span or nothing
	assign span_c = $signed({1'b0, cfg.max_power}) - $signed({1'b0, cfg.min_power});
	assign qv_c   = $signed(RAMP_W'(quot));

	always_comb begin
		case (ctrl.mode)
			RAMP_DIV:  ramp_c = span_c[SPAN_W-1] ? -qv_c : qv_c;
			RAMP_FLAT: ramp_c = RAMP_W'(span_c);
			default:   ramp_c = '0;
		endcase
	end

	// Add the floor, cap and apply direction
	assign lvl_c = $signed(RAMP_W'(cfg.min_power)) + ramp_c;
	assign lvl_x = LIM_W'(lvl_c);

	always_comb begin
		if (lvl_x > LIM) begin
			clx_c = LIM;
		end else if (lvl_x < -LIM) begin
			clx_c = -LIM;
		end else begin
			clx_c = lvl_x;
		end
		cl_c = clx_c[RAMP_W-1:0];
		case (cfg.direction)
			DIR_STOP: base_c = '0;
			DIR_FWD:  base_c = cl_c;
			default:  base_c = -cl_c;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ld1) begin
			base_s1 <= base_c;
			prod_s1 <= prod;
			done_s1 <= ctrl.done;
			tout_s1 <= ctrl.tout;
		end
	end

	// Apply drift correction in Q8.8
	assign scaled_c = SUM_W'(base_s1) <<< FRAC_W;

	always_ff @(posedge clk) begin
		if (ld2) begin
			pl_s2   <= scaled_c - SUM_W'(prod_s1);
			pr_s2   <= scaled_c + SUM_W'(prod_s1);
			done_s2 <= done_s1;
			tout_s2 <= tout_s1;
		end
	end

	// Drop power once finished and hold the command beat
	always_ff @(posedge clk) begin
		if (ld3) begin
			left_s3  <= done_s2 ? '0 : to_cmd(pl_s2);
			right_s3 <= done_s2 ? '0 : to_cmd(pr_s2);
			done_s3  <= done_s2;
			tout_s3  <= tout_s2;
		end
	end

	assign out_valid   = v_s3;
	assign left_power  = left_s3;
	assign right_power = right_s3;
	assign finished    = done_s3;
	assign timed_out   = tout_s3;

endmodule

// ===== test/tb.sv =====
// Self-checking bench for the straight-drive ramp profile unit: random and directed beats.
module tb;
	import sdrp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int COUNT_WIDTH = 24;
	localparam int POWER_LIMIT = 127;
	localparam int MAX_COUNT   = 8388607;
	localparam int MIN_COUNT   = -8388608;
	localparam int PHASES      = 12;
	localparam int PHASE_BEATS = 120;
	localparam int LONG_HOLD   = 200;

	typedef struct {
		logic signed [COUNT_WIDTH-1:0] left_count;
		logic signed [COUNT_WIDTH-1:0] right_count;
		logic [TIME_W-1:0]             elapsed_ms;
	} sample_t;

	typedef struct {
		logic signed [OUT_W-1:0] left_power;
		logic signed [OUT_W-1:0] right_power;
		logic                    finished;
		logic                    timed_out;
	} command_t;

	logic clk = 1'b0;
	logic arst_n;
	logic wr_en;
	logic [IDX_W-1:0] wr_index;
	logic [REG_W-1:0] wr_data;

	sdrp_sample_if #(.COUNT_WIDTH(COUNT_WIDTH)) sample_ch ();
	sdrp_command_if command_ch ();

	straight_drive_ramp_profile_unit #(
		.COUNT_WIDTH(COUNT_WIDTH),
		.POWER_LIMIT(POWER_LIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample_ch),
		.command(command_ch),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	// Bench copy of the register file and the traffic stores
	cfg_t     drive_cfg = CFG_RESET;
	sample_t  sample_backlog[$];
	command_t command_due[$];
	sample_t  next_sample;
	command_t got_command;
	command_t want_command;

	int mismatch_count = 0;
	int src_odds = 0;
	int sink_odds = 0;
	int src_gap;
	int sink_gap;
	int hold_asked = 0;
	int hold_served;

	always #10 clk = ~clk;

	function automatic longint limit(longint v, longint lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	// Work out the motor command that one sample beat must produce
	function automatic command_t power_command_for(logic signed [COUNT_WIDTH-1:0] l,
		logic signed [COUNT_WIDTH-1:0] r, logic [TIME_W-1:0] el);
		longint lc, rc, avg, drift, span, ramp, base, twist, lp, rp;
		longint total, accel, decel, floor_pwr, peak, gain;
		int dir;
		command_t c;
		lc = longint'(l);
		rc = longint'(r);
		avg = (lc + rc) / 2;
		if (avg < 0) avg = -avg;
		drift = lc - rc;
		total = longint'(drive_cfg.total_distance);
		accel = longint'(drive_cfg.accel_distance);
		decel = longint'(drive_cfg.decel_start);
		floor_pwr = longint'(drive_cfg.min_power);
		peak = longint'(drive_cfg.max_power);
		gain = longint'(drive_cfg.drift_gain);
		span = peak - floor_pwr;
		c.timed_out = el > drive_cfg.timeout_ms;
		c.finished = c.timed_out || (avg >= total);
		c.left_power = '0;
		c.right_power = '0;
		if (!c.finished) begin
			// Trapezoid: rise, flat top, fall towards the target
			if (avg <= accel) begin
				ramp = (accel > 0) ? (avg * span) / accel : 0;
			end else if (avg >= decel) begin
				ramp = (total > decel) ? ((total - avg) * span) / (total - decel) : 0;
			end else begin
				ramp = span;
			end
			if (drive_cfg.direction == DIR_FWD) dir = 1;
			else if (drive_cfg.direction == DIR_STOP) dir = 0;
			else dir = -1;
			base = dir * limit(floor_pwr + ramp, POWER_LIMIT);
			// Steer against drift, gain in Q8.8
			twist = gain * drift;
			lp = limit((base * 256 - twist) / 256, OUT_LIMIT);
			rp = limit((base * 256 + twist) / 256, OUT_LIMIT);
			c.left_power = lp[OUT_W-1:0];
			c.right_power = rp[OUT_W-1:0];
		end
		return c;
	endfunction

	task automatic flag_mismatch(string what);
		$display("ERROR at %0t: %s", $realtime, what);
		mismatch_count++;
	endtask

	// Sample driver: predict on each accepted beat, then offer the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_ch.valid <= 1'b0;
			sample_ch.left_count <= '0;
			sample_ch.right_count <= '0;
			sample_ch.elapsed_ms <= '0;
			src_gap <= 0;
		end else begin
			if (sample_ch.valid && sample_ch.ready)
				command_due.push_back(power_command_for(sample_ch.left_count,
					sample_ch.right_count, sample_ch.elapsed_ms));
			if (!sample_ch.valid || sample_ch.ready) begin
				if (src_gap > 0) begin
					sample_ch.valid <= 1'b0;
					src_gap <= src_gap - 1;
				end else if (sample_backlog.size() > 0 && src_odds > 0 &&
						$urandom_range(1, src_odds) == 1) begin
					sample_ch.valid <= 1'b0;
					src_gap <= $urandom_range(0, 18);
				end else if (sample_backlog.size() > 0) begin
					next_sample = sample_backlog.pop_front();
					sample_ch.valid <= 1'b1;
					sample_ch.left_count <= next_sample.left_count;
					sample_ch.right_count <= next_sample.right_count;
					sample_ch.elapsed_ms <= next_sample.elapsed_ms;
				end else begin
					sample_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Command monitor: check each beat against the oldest prediction, then pace ready
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			command_ch.ready <= 1'b0;
			sink_gap <= 0;
			hold_served <= 0;
		end else begin
			if (command_ch.valid && command_ch.ready) begin
				got_command.left_power = command_ch.left_power;
				got_command.right_power = command_ch.right_power;
				got_command.finished = command_ch.finished;
				got_command.timed_out = command_ch.timed_out;
				if (command_due.size() == 0) begin
					flag_mismatch("command beat with no prediction waiting");
				end else begin
					want_command = command_due.pop_front();
					if (got_command.left_power !== want_command.left_power)
						flag_mismatch($sformatf("left_power %0d, predicted %0d",
							got_command.left_power, want_command.left_power));
					if (got_command.right_power !== want_command.right_power)
						flag_mismatch($sformatf("right_power %0d, predicted %0d",
							got_command.right_power, want_command.right_power));
					if (got_command.finished !== want_command.finished)
						flag_mismatch($sformatf("finished %b, predicted %b",
							got_command.finished, want_command.finished));
					if (got_command.timed_out !== want_command.timed_out)
						flag_mismatch($sformatf("timed_out %b, predicted %b",
							got_command.timed_out, want_command.timed_out));
				end
			end
			if (hold_served != hold_asked) begin
				command_ch.ready <= 1'b0;
				sink_gap <= LONG_HOLD;
				hold_served <= hold_served + 1;
			end else if (sink_gap > 0) begin
				command_ch.ready <= 1'b0;
				sink_gap <= sink_gap - 1;
			end else if (sink_odds > 0 && $urandom_range(1, sink_odds) == 1) begin
				command_ch.ready <= 1'b0;
				sink_gap <= $urandom_range(0, 18);
			end else begin
				command_ch.ready <= 1'b1;
			end
		end
	end

	task automatic queue_sample(int l, int r, int el);
		sample_t smp;
		smp.left_count = COUNT_WIDTH'(l);
		smp.right_count = COUNT_WIDTH'(r);
		smp.elapsed_ms = TIME_W'(el);
		@(negedge clk);
		sample_backlog.push_back(smp);
	endtask

	// Hold until every beat is through and the pipeline has emptied
	task automatic wait_quiet();
		while (sample_backlog.size() != 0 || sample_ch.valid || command_due.size() != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);
	endtask

	task automatic write_reg(reg_index_t idx, logic [REG_W-1:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
	endtask

	task automatic load_profile(cfg_t c);
		write_reg(REG_DIRECTION, {{(REG_W-DIR_W){1'b0}}, c.direction});
		write_reg(REG_TOTAL, c.total_distance);
		write_reg(REG_ACCEL, c.accel_distance);
		write_reg(REG_DECEL, c.decel_start);
		write_reg(REG_MAX_POWER, REG_W'(c.max_power));
		write_reg(REG_MIN_POWER, REG_W'(c.min_power));
		write_reg(REG_DRIFT_GAIN, {{(REG_W-GAIN_W){1'b0}}, c.drift_gain});
		write_reg(REG_TIMEOUT, REG_W'(c.timeout_ms));
		@(posedge clk);
		wr_en <= 1'b0;
		drive_cfg = c;
	endtask

	function automatic cfg_t random_profile();
		cfg_t c;
		int total, accel;
		c.direction = DIR_W'($urandom_range(0, 3));
		case ($urandom_range(0, 3))
			0: total = $urandom_range(0, 200);
			3: total = $urandom_range(0, MAX_COUNT);
			default: total = $urandom_range(0, 50000);
		endcase
		accel = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, total);
		c.total_distance = DIST_W'(total);
		c.accel_distance = DIST_W'(accel);
		if ($urandom_range(0, 7) == 0)
			c.decel_start = DIST_W'($urandom_range(total, MAX_COUNT));
		else
			c.decel_start = DIST_W'($urandom_range(accel, total));
		c.max_power = PWR_W'($urandom_range(0, 127));
		c.min_power = PWR_W'($urandom_range(0, 127));
		c.drift_gain = GAIN_W'($urandom_range(0, 65535));
		c.timeout_ms = TIME_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
			: $urandom_range(1000, 65535));
		return c;
	endfunction

	// Aim samples at the trapezoid corners, the target and the timeout edge
	task automatic queue_shaped_sample();
		int total, tmo, a, s, d, l, r, el;
		total = int'(drive_cfg.total_distance);
		tmo = int'(drive_cfg.timeout_ms);
		if ($urandom_range(0, 9) == 0) begin
			queue_sample($urandom, $urandom, $urandom_range(0, 65535));
		end else begin
			case ($urandom_range(0, 4))
				0: a = int'(drive_cfg.accel_distance) + int'($urandom_range(0, 4)) - 2;
				1: a = int'(drive_cfg.decel_start) + int'($urandom_range(0, 4)) - 2;
				2: a = total + int'($urandom_range(0, 4)) - 2;
				default: a = $urandom_range(0, total + total / 8 + 2);
			endcase
			if (a < 0) a = 0;
			if (a > MAX_COUNT) a = MAX_COUNT;
			s = 2 * a + int'($urandom_range(0, 1));
			if ($urandom_range(0, 1)) s = -s;
			if ($urandom_range(0, 3) == 0) d = int'($urandom_range(0, 2097152)) - 1048576;
			else d = int'($urandom_range(0, 400)) - 200;
			l = (s + d) / 2;
			r = s - l;
			if (l > MAX_COUNT || l < MIN_COUNT || r > MAX_COUNT || r < MIN_COUNT) begin
				l = s / 2;
				r = l;
			end
			case ($urandom_range(0, 7))
				0: el = tmo + int'($urandom_range(0, 4)) - 2;
				1: el = $urandom_range(0, 65535);
				default: el = $urandom_range(0, tmo);
			endcase
			if (el < 0) el = 0;
			if (el > 65535) el = 65535;
			queue_sample(l, r, el);
		end
	endtask

	// Stimulus sequence
	initial begin
		cfg_t prof;
		int p, k;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_DIRECTION;
		wr_data = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// Defaults after reset: zero target, so every beat is finished
		queue_sample(0, 0, 0);
		queue_sample(100, -50, 65535);
		queue_sample(MIN_COUNT, MIN_COUNT, 65535);
		wait_quiet();

		// Directed beats on a mid-range trapezoid
		prof = '{direction: DIR_FWD, total_distance: 10000, accel_distance: 2000,
			decel_start: 8000, max_power: 100, min_power: 20, drift_gain: 256,
			timeout_ms: 5000};
		load_profile(prof);
		queue_sample(0, 0, 0);
		queue_sample(2000, 2000, 10);
		queue_sample(1001, 1000, 10);
		queue_sample(-3001, -3000, 10);
		queue_sample(8000, 8000, 10);
		queue_sample(9999, 9999, 10);
		queue_sample(10000, 10000, 10);
		queue_sample(5000, 5000, 5000);
		queue_sample(5000, 5000, 5001);
		queue_sample(5000, 5000, 65535);
		queue_sample(MAX_COUNT, MIN_COUNT, 0);
		queue_sample(MIN_COUNT, MAX_COUNT, 0);
		queue_sample(MAX_COUNT, MAX_COUNT, 0);
		queue_sample(5100, 4900, 0);
		queue_sample(-4900, -5100, 0);
		wait_quiet();

		for (p = 0; p < PHASES; p++) begin
			case (p)
				0: prof = '{direction: 2'sb11, total_distance: MAX_COUNT,
					accel_distance: MAX_COUNT, decel_start: MAX_COUNT - 1, max_power: 127,
					min_power: 0, drift_gain: 16'sh7FFF, timeout_ms: 16'hFFFF};
				1: prof = '{direction: DIR_STOP, total_distance: 500, accel_distance: 0,
					decel_start: 400, max_power: 50, min_power: 90,
					drift_gain: 16'sh8000, timeout_ms: 100};
				2: prof = '{direction: 2'sb10, total_distance: 3000, accel_distance: 1000,
					decel_start: 3000, max_power: 0, min_power: 127,
					drift_gain: 16'shFFFF, timeout_ms: 0};
				3: prof = '{direction: DIR_FWD, total_distance: 1000,
					accel_distance: MAX_COUNT, decel_start: 0, max_power: 127,
					min_power: 127, drift_gain: 1, timeout_ms: 40000};
				default: prof = random_profile();
			endcase
			load_profile(prof);
			@(negedge clk);
			if (p == PHASES - 1) begin
				src_odds = 0;
				sink_odds = 0;
			end else begin
				case ($urandom_range(0, 3))
					0: src_odds = 0;
					1: src_odds = 3;
					2: src_odds = 8;
					default: src_odds = 25;
				endcase
				case ($urandom_range(0, 3))
					0: sink_odds = 0;
					1: sink_odds = 3;
					2: sink_odds = 8;
					default: sink_odds = 25;
				endcase
			end
			for (k = 0; k < PHASE_BEATS; k++) begin
				// Stall the sender once until every prediction is met
				if (p == 6 && k == PHASE_BEATS / 2) wait_quiet();
				queue_shaped_sample();
				// Hold off the receiver once while beats keep coming
				if (p == 5 && k == 20) hold_asked = hold_asked + 1;
			end
			wait_quiet();
		end

		repeat (20) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("straight_drive_ramp_profile_unit: match");
		end else begin
			$display("straight_drive_ramp_profile_unit: mismatch");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#20_000_000;
		$display("straight_drive_ramp_profile_unit: mismatch");
		$finish;
	end

endmodule

// ===== straight_drive_ramp_profile_unit.f =====
rtl/core/sdrp_pkg.sv
rtl/core/sdrp_sample_if.sv
rtl/core/sdrp_command_if.sv
rtl/core/sdrp_front.sv
rtl/core/sdrp_div.sv
rtl/core/sdrp_mix.sv
rtl/core/straight_drive_ramp_profile_unit.sv
test/tb.sv
